### rtl/lfu_pkg.sv
package lfu_pkg;

   // Storage geometry
   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 31;
   localparam int CAP_BITS   = 5;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_BITS  = IDX_BITS;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = (CAP_BITS > OCC_BITS) ? CAP_BITS : OCC_BITS;

   // Register map
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [RANK_BITS-1:0]  rank_type;
   typedef logic [OCC_BITS-1:0]   occ_type;
   typedef logic [CAP_BITS-1:0]   cap_type;

   localparam cap_type   CAP_RESET = CAP_BITS'(16);
   localparam count_type COUNT_MAX = '1;
   localparam count_type COUNT_ONE = COUNT_BITS'(1);

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_UNMAPPED = 1'b1
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_INSERT,
      UPD_REPLACE
   } upd_op_type;

   // Token handed from cell to cell during the search
   typedef struct packed {
      logic      hit;
      idx_type   hit_idx;
      rank_type  hit_rank;
      key_type   hit_data;
      occ_type   occ;
      logic      vic_ok;
      idx_type   vic_idx;
      count_type vic_count;
      rank_type  vic_rank;
      key_type   vic_key;
      logic      free_ok;
      idx_type   free_idx;
   } scan_type;

   // Command broadcast to every cell at the end of an item
   typedef struct packed {
      upd_op_type op;
      idx_type    idx;
      rank_type   rank;
      logic       put;
      key_type    key;
      key_type    data;
   } upd_type;

endpackage

### rtl/lfu_cell.sv
module lfu_cell import lfu_pkg::*; #(
   parameter idx_type CELL_INDEX = '0
) (
   input  logic     clock,
   input  logic     reset,
   input  key_type  item_key,
   input  scan_type scan_in,
   output scan_type scan_out,
   input  upd_type  upd,
   output logic     valid_out
);

   logic      valid_ff, valid_in;
   key_type   key_ff, key_in;
   key_type   data_ff, data_in;
   count_type count_ff, count_in;
   rank_type  rank_ff, rank_in;
   scan_type  scan_ff, scan_in_nxt;
   logic      self;
   logic      older;

   // Fold this entry into the passing token
   always_comb begin
      older = 1'b0;
      scan_in_nxt = scan_in;
      scan_in_nxt.occ = scan_in.occ + OCC_BITS'(valid_ff);
      if (valid_ff && key_ff == item_key) begin
         scan_in_nxt.hit      = 1'b1;
         scan_in_nxt.hit_idx  = CELL_INDEX;
         scan_in_nxt.hit_rank = rank_ff;
         scan_in_nxt.hit_data = data_ff;
      end
      if (valid_ff) begin
         older = (count_ff == scan_in.vic_count) && (rank_ff > scan_in.vic_rank);
         if (!scan_in.vic_ok || count_ff < scan_in.vic_count || older) begin
            scan_in_nxt.vic_ok    = 1'b1;
            scan_in_nxt.vic_idx   = CELL_INDEX;
            scan_in_nxt.vic_count = count_ff;
            scan_in_nxt.vic_rank  = rank_ff;
            scan_in_nxt.vic_key   = key_ff;
         end
      end else if (!scan_in.free_ok) begin
         scan_in_nxt.free_ok  = 1'b1;
         scan_in_nxt.free_idx = CELL_INDEX;
      end
   end

   // Apply the broadcast update
   always_comb begin
      self     = (upd.idx == CELL_INDEX);
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      case (upd.op)
         UPD_TOUCH: begin
            if (self) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_ONE;
               end
               rank_in = '0;
               if (upd.put) begin
                  data_in = upd.data;
               end
            end else if (valid_ff && rank_ff < upd.rank) begin
               rank_in = rank_ff + RANK_BITS'(1);
            end
         end
         UPD_INSERT, UPD_REPLACE: begin
            if (self) begin
               valid_in = 1'b1;
               key_in   = upd.key;
               data_in  = upd.data;
               count_in = COUNT_ONE;
               rank_in  = '0;
            end else if (valid_ff) begin
               // entries older than the victim close the gap, then all age by one
               if (!(upd.op == UPD_REPLACE && rank_ff > upd.rank)) begin
                  rank_in = rank_ff + RANK_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
      scan_ff <= scan_in_nxt;
   end

   assign scan_out  = scan_ff;
   assign valid_out = valid_ff;

endmodule

### rtl/lfu_cache_lru_tiebreak.sv
// LFU cache with LRU tie-break: a key-value store of ENTRIES slots.
// Request channel (req_valid/req_ready): one get or put per transfer,
// with cmd, key and value. Response channel (rsp_valid/rsp_ready): one
// transfer per request, carrying found, read_value, evicted and
// evicted_key, in request order.
// Each slot lives in one cell of a chain. After a request is taken, a
// search token walks the chain one cell per cycle, collecting the hit,
// the occupancy, the first free slot and the eviction victim (lowest
// use count, oldest on a tie). An update step then broadcasts the update to
// all cells and loads the response register.
// The block takes no new request until the current one has walked the
// chain and been answered. req_ready is high while the block waits for work,
// also while a response is still held for the receiver.
// A stalled receiver holds the response register; the block then waits
// at the update step with the cache unchanged until the slot frees up.
// Reset empties the cache and sets capacity_in_use (APB register at
// byte address 0) to 16. Write it only while the block is idle.
module lfu_cache_lru_tiebreak import lfu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic [KEY_BITS-1:0]      req_key,
   input  logic [KEY_BITS-1:0]      req_value,
   // response
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_found,
   output logic [KEY_BITS-1:0]      rsp_read_value,
   output logic                     rsp_evicted,
   output logic [KEY_BITS-1:0]      rsp_evicted_key,
   // configuration
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   state_type state_ff, state_in;
   idx_type   cnt_ff, cnt_in;
   cmd_type   cmd_ff;
   key_type   key_ff, value_ff;
   cap_type   cap_ff, cap_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      found_ff, found_in;
   key_type   read_value_ff, read_value_in;
   logic      evicted_ff, evicted_in;
   key_type   evicted_key_ff, evicted_key_in;

   scan_type  scan_bus [ENTRIES+1];
   scan_type  scan_last;
   upd_type   upd;
   logic      [ENTRIES-1:0] valid_vec;
   logic      take;
   logic      fire;
   logic      full;
   logic      cap_zero;
   logic      [CMP_BITS-1:0] cap_eff;
   reg_type   reg_sel;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign reg_sel = reg_type'(paddr[CSR_ADDR_BITS-1]);
   assign prdata  = (reg_sel == REG_CAPACITY) ? CSR_DATA_BITS'(cap_ff) : '0;

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && pready && reg_sel == REG_CAPACITY) begin
         cap_in = pwdata[CAP_BITS-1:0];
      end
   end

   // ---------------- cell chain ----------------
   // The token enters empty at the head of the chain.
   assign scan_bus[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfu_cell #(
         .CELL_INDEX (IDX_BITS'(g))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .item_key  (key_ff),
         .scan_in   (scan_bus[g]),
         .scan_out  (scan_bus[g+1]),
         .upd       (upd),
         .valid_out (valid_vec[g])
      );
   end

   assign scan_last = scan_bus[ENTRIES];

   // ---------------- decision ----------------
   // Clamp the capacity to the number of slots; full means a put miss must evict.
   always_comb begin
      cap_eff = (CMP_BITS'(cap_ff) > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES)
                                                          : CMP_BITS'(cap_ff);
      cap_zero = (cap_ff == '0);
      full     = CMP_BITS'(scan_last.occ) >= cap_eff;
   end

   assign take = req_valid && req_ready;

   // next state, update broadcast and response
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      req_ready      = 1'b0;
      fire           = 1'b0;
      upd            = '0;
      upd.op         = UPD_NONE;
      upd.put        = (cmd_ff == CMD_PUT);
      upd.key        = key_ff;
      upd.data       = value_ff;
      found_in       = 1'b0;
      read_value_in  = '0;
      evicted_in     = 1'b0;
      evicted_key_in = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            // advance until the token has left the last cell
            if (cnt_ff == IDX_BITS'(ENTRIES - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + IDX_BITS'(1);
            end
         end
         ST_UPDATE: begin
            fire = !rsp_valid_ff || rsp_ready;
            if (!cap_zero) begin
               if (scan_last.hit) begin
                  upd.op   = UPD_TOUCH;
                  upd.idx  = scan_last.hit_idx;
                  upd.rank = scan_last.hit_rank;
                  found_in = 1'b1;
                  if (cmd_ff == CMD_GET) begin
                     read_value_in = scan_last.hit_data;
                  end
               end else if (cmd_ff == CMD_PUT) begin
                  if (full) begin
                     upd.op         = UPD_REPLACE;
                     upd.idx        = scan_last.vic_idx;
                     upd.rank       = scan_last.vic_rank;
                     evicted_in     = 1'b1;
                     evicted_key_in = scan_last.vic_key;
                  end else begin
                     upd.op  = UPD_INSERT;
                     upd.idx = scan_last.free_idx;
                  end
               end
            end
            // hold the cache unchanged while the response slot is busy
            if (!fire) begin
               upd.op = UPD_NONE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff   <= cmd_type'(req_cmd);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (fire) begin
         found_ff       <= found_in;
         read_value_ff  <= read_value_in;
         evicted_ff     <= evicted_in;
         evicted_key_ff <= evicted_key_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

   // ---------------- assertions ----------------
   a_occ_matches : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> scan_last.occ == OCC_BITS'($countones(valid_vec)))
      else $error("chain occupancy disagrees with the valid cells");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      upd.op == UPD_INSERT |=>
         $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("insert did not add exactly one entry");

   a_replace_keeps : assert property (@(posedge clock) disable iff (reset)
      upd.op == UPD_REPLACE || upd.op == UPD_TOUCH |=> $stable(valid_vec))
      else $error("replace or touch changed the set of valid slots");

   a_victim_found : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE && !cap_zero && full |-> scan_last.vic_ok)
      else $error("cache full but no eviction candidate found");

   a_free_found : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE && !cap_zero && !full |-> scan_last.free_ok)
      else $error("cache not full but no free slot found");

endmodule
